>>> rtl/core/jswd_pkg.sv
// Shared types, codes and constants of the job supervisor watchdog.
`default_nettype none
package jswd_pkg;

   localparam logic [7:0]  MAX_DEPTH        = 8'd255;
   localparam logic [31:0] DEFAULT_BUDGET   = 32'd10000;
   localparam logic [19:0] DEFAULT_CRITICAL = 20'd950000;

   // Register select values, decoded on address bit 2 (byte addresses 0 and 4).
   localparam logic REG_BUDGET   = 1'b0;
   localparam logic REG_CRITICAL = 1'b1;

   typedef enum logic [2:0] {
      KIND_START     = 3'd0,
      KIND_END       = 3'd1,
      KIND_HEARTBEAT = 3'd2,
      KIND_RECOVER   = 3'd3,
      KIND_SAFE      = 3'd4
   } kind_type;

   localparam logic [2:0] CODE_IDLE     = 3'd0;
   localparam logic [2:0] CODE_THINK    = 3'd1;
   localparam logic [2:0] CODE_EXEC     = 3'd2;
   localparam logic [2:0] CODE_TIMEOUT  = 3'd3;
   localparam logic [2:0] CODE_THROTTLE = 3'd4;
   localparam logic [2:0] CODE_ERROR    = 3'd5;
   localparam logic [2:0] CODE_SHUTDOWN = 3'd6;

   typedef enum logic [6:0] {
      MODE_IDLE     = 7'b0000001,
      MODE_THINK    = 7'b0000010,
      MODE_EXEC     = 7'b0000100,
      MODE_TIMEOUT  = 7'b0001000,
      MODE_THROTTLE = 7'b0010000,
      MODE_ERROR    = 7'b0100000,
      MODE_SHUTDOWN = 7'b1000000
   } mode_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic        success;
      logic [31:0] latency_ms;
      logic [19:0] utilization;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic        granted;
      logic [2:0]  state_code;
      logic [7:0]  depth;
      logic [31:0] last_latency;
      logic [31:0] recovery_total;
      logic        throttled;
   } rsp_type;

   typedef struct packed {
      logic [31:0] timeout_budget_ms;
      logic [19:0] critical_utilization;
   } cfg_type;

   // Set of legal targets for each source state, as a mask of one-hot state codes.
   function automatic logic [6:0] legal_targets(input mode_type from);
      logic [6:0] mask;
      case (from)
         MODE_IDLE:     mask = MODE_THINK | MODE_EXEC | MODE_SHUTDOWN;
         MODE_THINK:    mask = MODE_EXEC | MODE_THROTTLE | MODE_ERROR | MODE_IDLE
                               | MODE_SHUTDOWN;
         MODE_EXEC:     mask = MODE_THINK | MODE_TIMEOUT | MODE_ERROR | MODE_THROTTLE
                               | MODE_SHUTDOWN;
         MODE_TIMEOUT:  mask = MODE_ERROR | MODE_THINK | MODE_IDLE | MODE_SHUTDOWN;
         MODE_THROTTLE: mask = MODE_EXEC | MODE_THINK | MODE_ERROR | MODE_IDLE
                               | MODE_SHUTDOWN;
         MODE_ERROR:    mask = MODE_IDLE | MODE_THINK | MODE_SHUTDOWN;
         default:       mask = 7'd0;
      endcase
      return mask;
   endfunction

   // An illegal move leaves the state where it is.
   function automatic mode_type move_to(input mode_type from, input mode_type target);
      mode_type result;
      if ((target == from) || ((legal_targets(from) & target) != 7'd0)) begin
         result = target;
      end else begin
         result = from;
      end
      return result;
   endfunction

   function automatic logic [2:0] mode_code(input mode_type mode);
      logic [2:0] code;
      case (mode)
         MODE_IDLE:     code = CODE_IDLE;
         MODE_THINK:    code = CODE_THINK;
         MODE_EXEC:     code = CODE_EXEC;
         MODE_TIMEOUT:  code = CODE_TIMEOUT;
         MODE_THROTTLE: code = CODE_THROTTLE;
         MODE_ERROR:    code = CODE_ERROR;
         MODE_SHUTDOWN: code = CODE_SHUTDOWN;
         default:       code = CODE_IDLE;
      endcase
      return code;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/jswd_csr.sv
// Configuration registers of the job supervisor behind an APB-style port.
`default_nettype none
module jswd_csr (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_psel,
   input  wire logic            csr_penable,
   input  wire logic            csr_pwrite,
   input  wire logic [2:0]      csr_paddr,
   input  wire logic [31:0]     csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output jswd_pkg::cfg_type    cfg
);
   import jswd_pkg::*;

   logic [31:0] budget_ff;
   logic [31:0] budget_in;
   logic [19:0] critical_ff;
   logic [19:0] critical_in;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      budget_in   = budget_ff;
      critical_in = critical_ff;
      if (wr_en) begin
         case (csr_paddr[2])
            REG_BUDGET: begin
               // A budget of zero falls back to the default.
               budget_in = (csr_pwdata != 32'd0) ? csr_pwdata : DEFAULT_BUDGET;
            end
            REG_CRITICAL: begin
               critical_in = csr_pwdata[19:0];
            end
            default: begin
               budget_in = budget_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff   <= DEFAULT_BUDGET;
         critical_ff <= DEFAULT_CRITICAL;
      end else begin
         budget_ff   <= budget_in;
         critical_ff <= critical_in;
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_BUDGET:   csr_prdata = budget_ff;
         REG_CRITICAL: csr_prdata = {12'd0, critical_ff};
         default:      csr_prdata = 32'd0;
      endcase
   end

   assign cfg.timeout_budget_ms    = budget_ff;
   assign cfg.critical_utilization = critical_ff;

endmodule
`default_nettype wire

>>> rtl/core/jswd_core.sv
// Supervisor state registers and the single-pass event update logic.
`default_nettype none
module jswd_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire jswd_pkg::req_type item,
   input  wire jswd_pkg::cfg_type cfg,
   output jswd_pkg::rsp_type      result
);
   import jswd_pkg::*;

   mode_type    mode_ff;
   mode_type    mode_in;
   logic [7:0]  depth_ff;
   logic [7:0]  depth_in;
   logic [31:0] latency_ff;
   logic [31:0] latency_in;
   logic [31:0] recoveries_ff;
   logic [31:0] recoveries_in;
   logic [31:0] start_ff;
   logic [31:0] start_in;
   logic        armed_ff;
   logic        armed_in;

   logic        critical;
   logic        granted;
   logic [7:0]  depth_dec;
   logic [31:0] elapsed;
   logic        expired;

   assign critical  = item.utilization >= cfg.critical_utilization;
   assign depth_dec = (depth_ff != 8'd0) ? depth_ff - 8'd1 : 8'd0;
   assign elapsed   = item.now_ms - start_ff;
   assign expired   = armed_ff && (mode_ff == MODE_EXEC) && (elapsed > cfg.timeout_budget_ms);

   always_comb begin
      mode_in       = mode_ff;
      depth_in      = depth_ff;
      latency_in    = latency_ff;
      recoveries_in = recoveries_ff;
      start_in      = start_ff;
      armed_in      = armed_ff;
      granted       = 1'b0;
      case (item.kind)
         KIND_START: begin
            if (critical) begin
               mode_in = move_to(mode_ff, MODE_THROTTLE);
            end else begin
               if (depth_ff < MAX_DEPTH) begin
                  depth_in = depth_ff + 8'd1;
               end
               if ((mode_ff == MODE_IDLE) || (mode_ff == MODE_THINK)) begin
                  mode_in = move_to(mode_ff, MODE_EXEC);
               end
               start_in = item.now_ms;
               armed_in = 1'b1;
               granted  = 1'b1;
            end
         end
         KIND_END: begin
            latency_in = item.latency_ms;
            depth_in   = depth_dec;
            armed_in   = 1'b0;
            if (!item.success || (item.latency_ms > cfg.timeout_budget_ms)) begin
               mode_in       = move_to(mode_ff, MODE_TIMEOUT);
               recoveries_in = recoveries_ff + 32'd1;
            end else if (depth_dec == 8'd0) begin
               mode_in = move_to(mode_ff, MODE_THINK);
            end
         end
         KIND_HEARTBEAT: begin
            if (expired) begin
               armed_in      = 1'b0;
               depth_in      = 8'd0;
               mode_in       = move_to(mode_ff, MODE_TIMEOUT);
               recoveries_in = recoveries_ff + 32'd1;
            end else if (critical) begin
               armed_in      = 1'b0;
               depth_in      = 8'd0;
               mode_in       = move_to(mode_ff, MODE_ERROR);
               recoveries_in = recoveries_ff + 32'd1;
            end
         end
         KIND_RECOVER: begin
            mode_in       = move_to(mode_ff, MODE_ERROR);
            depth_in      = 8'd0;
            recoveries_in = recoveries_ff + 32'd1;
         end
         KIND_SAFE: begin
            if (critical) begin
               armed_in      = 1'b0;
               depth_in      = 8'd0;
               mode_in       = move_to(mode_ff, MODE_ERROR);
               recoveries_in = recoveries_ff + 32'd1;
               granted       = 1'b1;
            end
         end
         default: begin
            mode_in = mode_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         depth_ff      <= 8'd0;
         latency_ff    <= 32'd0;
         recoveries_ff <= 32'd0;
         start_ff      <= 32'd0;
         armed_ff      <= 1'b0;
      end else if (advance) begin
         mode_ff       <= mode_in;
         depth_ff      <= depth_in;
         latency_ff    <= latency_in;
         recoveries_ff <= recoveries_in;
         start_ff      <= start_in;
         armed_ff      <= armed_in;
      end
   end

   assign result.granted        = granted;
   assign result.state_code     = mode_code(mode_in);
   assign result.depth          = depth_in;
   assign result.last_latency   = latency_in;
   assign result.recovery_total = recoveries_in;
   assign result.throttled      = critical;

endmodule
`default_nettype wire

>>> rtl/core/job_supervisor_watchdog_fsm_top.sv
// Top level of the job supervisor watchdog: input register, update logic, result register.
// An event waits in the input register; its result is registered in the result register until taken.
// Throughput: one event per cycle unless results stall; the state update is one pass of compares and adds.
// A stalled result register holds its result while the input register still takes one event if it is empty.
// Reset (synchronous, active high) empties both registers, returns the supervisor to idle
// with zero depth, counters and watchdog, and loads the default budget and threshold.
`default_nettype none
module job_supervisor_watchdog_fsm_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_kind,
   input  wire logic        req_success,
   input  wire logic [31:0] req_latency_ms,
   input  wire logic [19:0] req_utilization,
   input  wire logic [31:0] req_now_ms,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_granted,
   output logic [2:0]       rsp_state_code,
   output logic [7:0]       rsp_depth,
   output logic [31:0]      rsp_last_latency,
   output logic [31:0]      rsp_recovery_total,
   output logic             rsp_throttled,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import jswd_pkg::*;

   cfg_type cfg;
   req_type item_ff;
   req_type item_in;
   logic    item_valid_ff;
   logic    item_valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_in;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type result;
   logic    advance;
   logic    req_take;

   jswd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   jswd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // The held event moves on whenever the result register is empty or being emptied.
   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      item_in.kind        = req_kind;
      item_in.success     = req_success;
      item_in.latency_ms  = req_latency_ms;
      item_in.utilization = req_utilization;
      item_in.now_ms      = req_now_ms;
      item_valid_in       = req_take || (item_valid_ff && !advance);
      rsp_in              = result;
      rsp_valid_in        = advance || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_granted        = rsp_ff.granted;
   assign rsp_state_code     = rsp_ff.state_code;
   assign rsp_depth          = rsp_ff.depth;
   assign rsp_last_latency   = rsp_ff.last_latency;
   assign rsp_recovery_total = rsp_ff.recovery_total;
   assign rsp_throttled      = rsp_ff.throttled;

   // Only a job start or a safe-return check can grant.
   assert property (@(posedge clock) disable iff (reset)
      (advance && result.granted) |->
         ((item_ff.kind == KIND_START) || (item_ff.kind == KIND_SAFE)))
      else $error("grant raised by an event that cannot grant");

   // Shutdown has no way out.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.state_code == CODE_SHUTDOWN) && advance) |=>
         (rsp_ff.state_code == CODE_SHUTDOWN))
      else $error("supervisor left shutdown");

   // A recovery request always clears the nesting depth and leaves a valid result; it also counts a recovery.
   assert property (@(posedge clock) disable iff (reset)
      (advance && (item_ff.kind == KIND_RECOVER)) |=>
         ((rsp_ff.depth == 8'd0) && rsp_valid_ff))
      else $error("recovery request left a non-zero depth");

   // A result transfer is never lost: a held result stays until taken.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && !advance) || rsp_valid_ff)
      else $error("pending result dropped");

endmodule
`default_nettype wire
